@@ design/rsct_pkg.sv @@
// Package for the resizing stack unit: status and operation codes,
// the result record passed between stages, and the start capacity clamp.
// No dependencies.
`timescale 1ns / 1ps

package rsct_pkg;

    localparam int RSCT_DEPTH = 1024;

    localparam int START_W  = 11;
    localparam int COUNT_OW = 11;
    localparam int CAP_OW   = 12;
    localparam int DATA_W   = 32;

    localparam logic [START_W-1:0] START_RESET = START_W'(10);
    localparam logic [START_W-1:0] START_MIN   = START_W'(1);
    localparam logic [START_W-1:0] START_MAX   = START_W'(1024);

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        logic                is_pop;
        status_t             status;
        logic                grew;
        logic                shrank;
        logic [COUNT_OW-1:0] count;
        logic [CAP_OW-1:0]   capacity;
        logic [CAP_OW-1:0]   peak;
    } result_t;

    function automatic logic [START_W-1:0] clamp_start(input logic [START_W-1:0] value);
        logic [START_W-1:0] clamped;
        if (value == '0)
        begin
            clamped = START_MIN;
        end
        else if (value > START_MAX)
        begin
            clamped = START_MAX;
        end
        else
        begin
            clamped = value;
        end
        return clamped;
    endfunction

endpackage

@@ design/rsct_stack_ram.sv @@
// Stack storage for the resizing stack unit: one write port and one
// registered read port. Depends on rsct_pkg.
`timescale 1ns / 1ps

module rsct_stack_ram
    import rsct_pkg::*;
#(
    parameter int DEPTH = RSCT_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/rsct_ctrl.sv @@
// Count, capacity and peak tracking for the resizing stack unit, with the
// result register and the stack RAM access requests. Depends on rsct_pkg.
`timescale 1ns / 1ps

module rsct_ctrl
    import rsct_pkg::*;
#(
    parameter int DEPTH = RSCT_DEPTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int CAP_W = (CNT_W + 1 > CAP_OW) ? CNT_W + 1 : CAP_OW,
    localparam int CNT_EXT_W = (CNT_W > COUNT_OW) ? CNT_W : COUNT_OW
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [START_W-1:0] cfg_wdata,
    input  logic               in_valid,
    input  op_t                in_op,
    output logic               in_ready,
    output logic               ram_wr_en,
    output logic [AW-1:0]      ram_wr_addr,
    output logic               ram_rd_en,
    output logic [AW-1:0]      ram_rd_addr,
    output logic               res_valid,
    output result_t            res,
    input  logic               res_take
);

    logic [START_W-1:0] start_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [CAP_W-1:0]   peak_reg, peak_next;
    logic               res_valid_reg;
    result_t            res_reg, res_next;

    logic               accept;
    logic               full;
    logic               empty;
    logic               grow;
    logic               shrink;
    logic [CAP_W-1:0]   cap_grown;
    logic [CAP_W-1:0]   count_ext;
    logic [CAP_W-1:0]   count_inc_ext;
    logic [CNT_W-1:0]   count_inc;
    logic [START_W-1:0] start_clamped;
    logic [CNT_EXT_W-1:0] count_out_ext;

    assign in_ready = !res_valid_reg || res_take;
    assign accept   = in_valid && in_ready;

    assign full          = (count_reg == CNT_W'(DEPTH));
    assign empty         = (count_reg == '0);
    assign count_inc     = count_reg + CNT_W'(1);
    assign count_ext     = CAP_W'(count_reg);
    assign count_inc_ext = CAP_W'(count_inc);
    assign grow          = (count_ext >= cap_reg);
    assign cap_grown     = grow ? (cap_reg << 1) : cap_reg;
    // The halving test runs on the capacity after any doubling of this push.
    assign shrink        = (cap_grown != CAP_W'(start_reg))
                           && (count_inc_ext < (cap_grown >> 1));
    assign start_clamped = clamp_start(cfg_wdata);

    always_comb
    begin
        count_next      = count_reg;
        cap_next        = cap_reg;
        peak_next       = peak_reg;
        res_next.is_pop = (in_op == OP_POP);
        res_next.status = STATUS_OK;
        res_next.grew   = 1'b0;
        res_next.shrank = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        if (in_op == OP_PUSH)
        begin
            if (full)
            begin
                res_next.status = STATUS_FULL;
            end
            else
            begin
                ram_wr_en       = accept;
                count_next      = count_inc;
                cap_next        = shrink ? (cap_grown >> 1) : cap_grown;
                peak_next       = (cap_grown > peak_reg) ? cap_grown : peak_reg;
                res_next.grew   = grow;
                res_next.shrank = shrink;
            end
        end
        else
        begin
            if (empty)
            begin
                res_next.status = STATUS_EMPTY;
            end
            else
            begin
                ram_rd_en  = accept;
                count_next = count_reg - CNT_W'(1);
            end
        end
        count_out_ext     = CNT_EXT_W'(count_next);
        res_next.count    = count_out_ext[COUNT_OW-1:0];
        res_next.capacity = cap_next[CAP_OW-1:0];
        res_next.peak     = peak_next[CAP_OW-1:0];
    end

    assign ram_wr_addr = AW'(count_reg);
    assign ram_rd_addr = AW'(count_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= START_RESET;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(START_RESET);
            peak_reg      <= CAP_W'(START_RESET);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                // A new start capacity also starts an empty stack.
                start_reg <= start_clamped;
                count_reg <= '0;
                cap_reg   <= CAP_W'(start_clamped);
                peak_reg  <= CAP_W'(start_clamped);
            end
            else if (accept)
            begin
                count_reg <= count_next;
                cap_reg   <= cap_next;
                peak_reg  <= peak_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ design/resizing_stack_with_capacity_tracking_unit.sv @@
// Top level of the resizing stack unit: stream ports, stack RAM, control
// and the output register. Depends on rsct_pkg, rsct_ctrl and rsct_stack_ram.
`timescale 1ns / 1ps

// A stack of signed 32-bit words in a RAM of DEPTH entries that also tracks a
// logical capacity: a push into a full capacity doubles it, and a push that
// leaves the count below half a capacity other than the start capacity halves
// it. One push or pop is accepted every cycle unless a result waits untaken;
// each gives exactly one result, via the result register and then the output
// register, as the count, capacity and peak registers update on acceptance
// and the stack RAM has one write port and one registered read port. The two
// registers let one more transfer in while a result waits. Writing cfg_wdata
// with cfg_we high sets the start capacity (0 reads as 1, above 1024 as 1024)
// and empties the stack; write it only while the block is idle.

module resizing_stack_with_capacity_tracking_unit
    import rsct_pkg::*;
#(
    parameter int DEPTH = RSCT_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [START_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // s_tdata: push_value[31:0]
    input  logic [31:0]        s_tdata,
    // s_tuser: operation[0]
    input  logic [0:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // m_tdata: pop_value[31:0], grew[32], shrank[33], item_count_out[44:34],
    // capacity_out[56:45], max_capacity_out[68:57], zero fill[71:69]
    output logic [71:0]        m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]         m_tuser
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;
    logic              res_valid;
    logic              res_take;
    result_t           res;
    op_t               in_op;
    logic [DATA_W-1:0] pop_value;
    logic              out_valid_reg;
    logic [71:0]       out_data_reg;
    logic [1:0]        out_user_reg;

    assign in_op = op_t'(s_tuser[0]);

    rsct_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_op       (in_op),
        .in_ready    (s_tready),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    rsct_stack_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign res_take = res_valid && (!out_valid_reg || m_tready);

    // The RAM read data is held until the result moves on, since the next
    // read only happens when a new item is accepted.
    always_comb
    begin
        if (res.status == STATUS_EMPTY)
        begin
            pop_value = '1;
        end
        else if (res.is_pop)
        begin
            pop_value = ram_rd_data;
        end
        else
        begin
            pop_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= {3'b000, res.peak, res.capacity, res.count,
                             res.shrank, res.grew, pop_value};
            out_user_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ test/tb.sv @@
// Testbench for resizing_stack_with_capacity_tracking_unit: drives pushes and pops,
// predicts each result and compares every field. Depends on rsct_pkg and the unit.
`timescale 1ns / 1ps

module tb;
    import rsct_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [31:0]         value;
        status_t             status;
        logic                grew;
        logic                shrank;
        logic [COUNT_OW-1:0] count;
        logic [CAP_OW-1:0]   capacity;
        logic [CAP_OW-1:0]   peak;
    } stack_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [START_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;
    logic [0:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [71:0]        m_tdata;
    logic [1:0]         m_tuser;

    // Shadow copy of the stack and its capacity bookkeeping.
    logic [31:0] shadow_stack [RSCT_DEPTH];
    int          shadow_count;
    int          shadow_cap;
    int          shadow_peak;
    int          shadow_start;

    stack_result_t expected_results [$];

    int error_count;
    int cycle_count;
    int checked_count;
    int grow_seen;
    int shrink_seen;
    int empty_seen;
    int full_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;

    resizing_stack_with_capacity_tracking_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (error_count < 40)
        begin
            $display("Mismatch at cycle %0d on %s: got 0x%08h, expected 0x%08h",
                     cycle_count, field, got, want);
        end
        error_count++;
    endtask

    function automatic void empty_stack(input int start);
        shadow_start = start;
        shadow_count = 0;
        shadow_cap   = start;
        shadow_peak  = start;
    endfunction

    // Works out the result of one push or pop and advances the shadow state.
    function automatic stack_result_t predict_stack_op(input op_t op, input logic [31:0] val);
        stack_result_t r;
        r.value  = '0;
        r.status = STATUS_OK;
        r.grew   = 1'b0;
        r.shrank = 1'b0;
        if (op == OP_PUSH)
        begin
            if (shadow_count >= RSCT_DEPTH)
            begin
                r.status = STATUS_FULL;
                full_seen++;
            end
            else
            begin
                if (shadow_count >= shadow_cap)
                begin
                    shadow_cap = shadow_cap * 2;
                    if (shadow_peak < shadow_cap)
                    begin
                        shadow_peak = shadow_cap;
                    end
                    r.grew = 1'b1;
                    grow_seen++;
                end
                shadow_stack[shadow_count] = val;
                shadow_count++;
                if (shadow_cap != shadow_start && shadow_count < shadow_cap / 2)
                begin
                    shadow_cap = shadow_cap / 2;
                    r.shrank = 1'b1;
                    shrink_seen++;
                end
            end
        end
        else if (shadow_count == 0)
        begin
            r.value  = '1;
            r.status = STATUS_EMPTY;
            empty_seen++;
        end
        else
        begin
            shadow_count--;
            r.value = shadow_stack[shadow_count];
        end
        r.count    = COUNT_OW'(shadow_count);
        r.capacity = CAP_OW'(shadow_cap);
        r.peak     = CAP_OW'(shadow_peak);
        return r;
    endfunction

    // Result checker: every output transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                flag_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            end
            else
            begin
                want = expected_results.pop_front();
                checked_count++;
                if (m_tdata[31:0] !== want.value)
                    flag_mismatch("pop_value", m_tdata[31:0], want.value);
                if (m_tuser !== want.status)
                    flag_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[32] !== want.grew)
                    flag_mismatch("grew", 32'(m_tdata[32]), 32'(want.grew));
                if (m_tdata[33] !== want.shrank)
                    flag_mismatch("shrank", 32'(m_tdata[33]), 32'(want.shrank));
                if (m_tdata[44:34] !== want.count)
                    flag_mismatch("item_count_out", 32'(m_tdata[44:34]), 32'(want.count));
                if (m_tdata[56:45] !== want.capacity)
                    flag_mismatch("capacity_out", 32'(m_tdata[56:45]), 32'(want.capacity));
                if (m_tdata[68:57] !== want.peak)
                    flag_mismatch("max_capacity_out", 32'(m_tdata[68:57]), 32'(want.peak));
                if (m_tdata[71:69] !== 3'b000)
                    flag_mismatch("zero fill", 32'(m_tdata[71:69]), 32'h0);
            end
        end
    end

    function automatic int pick_gap(input int pct);
        int gap;
        gap = 0;
        if (pct > 0 && $urandom_range(0, 99) < pct)
        begin
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(10, 40);
            else
                gap = $urandom_range(1, 3);
        end
        return gap;
    endfunction

    // Output side back-pressure; m_tready gets one assignment per falling edge.
    initial
    begin
        m_tready  = 1'b0;
        recv_hold = 0;
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_tready = 1'b0;
            end
            else
            begin
                recv_hold = pick_gap(recv_idle_pct);
                if (recv_hold > 0)
                begin
                    recv_hold--;
                    m_tready = 1'b0;
                end
                else
                begin
                    m_tready = 1'b1;
                end
            end
        end
    end

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: w = 32'h8000_0000;
            1: w = 32'h7FFF_FFFF;
            2: w = 32'h0000_0000;
            3: w = 32'hFFFF_FFFF;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // Called at a falling edge; returns at a falling edge with tvalid still high.
    task automatic send_item(input op_t op, input logic [31:0] val);
        int gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = val;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        expected_results.push_back(predict_stack_op(op, val));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // The write also empties the stack, so it only happens with nothing in flight.
    task automatic set_start_capacity(input logic [START_W-1:0] value);
        int start;
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        if (value == 0)
            start = 1;
        else if (value > 1024)
            start = 1024;
        else
            start = value;
        empty_stack(start);
    endtask

    task automatic test_reset_state();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_item(OP_POP, 32'h1234_5678);
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_PUSH, 32'h7FFF_FFFF);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        // Eleven items in all crosses the reset capacity of ten and doubles it.
        repeat (7) send_item(OP_PUSH, random_word());
        repeat (6) send_item(OP_POP, random_word());
        // The count now sits below half the doubled capacity, so this push halves it.
        send_item(OP_PUSH, random_word());
        repeat (6) send_item(OP_POP, random_word());
        send_item(OP_POP, 32'h0);
    endtask

    task automatic test_start_extremes();
        set_start_capacity(11'd0);
        repeat (3) send_item(OP_PUSH, random_word());
        repeat (2) send_item(OP_POP, random_word());
        send_item(OP_PUSH, random_word());
        set_start_capacity(11'd2047);
        send_item(OP_PUSH, random_word());
        repeat (2) send_item(OP_POP, random_word());
    endtask

    task automatic test_store_full();
        set_start_capacity(11'd600);
        send_idle_pct = 3;
        recv_idle_pct = 3;
        repeat (RSCT_DEPTH) send_item(OP_PUSH, random_word());
        repeat (2) send_item(OP_PUSH, random_word());
        // Hold the input off until every outstanding result has been seen.
        wait_drained();
        repeat (4) send_item(OP_POP, random_word());
        send_item(OP_PUSH, random_word());
    endtask

    task automatic test_random_phase(input logic [START_W-1:0] start, input int items,
                                     input int send_pct, input int recv_pct);
        int sent;
        int run_len;
        int push_pct;
        set_start_capacity(start);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < items)
        begin
            // Alternate runs that mostly fill and mostly drain, so the capacity
            // both grows and halves.
            run_len  = $urandom_range(4, 40);
            push_pct = ($urandom_range(0, 2) == 0) ? 30 : 75;
            repeat (run_len)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    send_item(OP_PUSH, random_word());
                else
                    send_item(OP_POP, random_word());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_PUSH;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count   = 0;
        cycle_count   = 0;
        checked_count = 0;
        grow_seen     = 0;
        shrink_seen   = 0;
        empty_seen    = 0;
        full_seen     = 0;
        empty_stack(int'(START_RESET));
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_start_extremes();
        test_store_full();
        test_random_phase(11'd1, 50, 15, 15);
        test_random_phase(11'd2, 50, 0, 0);
        test_random_phase(11'd3, 50, 30, 10);
        test_random_phase(11'd10, 50, 10, 30);
        test_random_phase(11'd37, 50, 20, 20);
        test_random_phase(11'd1024, 40, 5, 40);
        test_random_phase(11'd5, 50, 25, 25);

        wait_drained();
        repeat (10) @(negedge clk);
        $display("Checked %0d results: %0d grows, %0d shrinks, %0d empty pops,",
                 checked_count, grow_seen, shrink_seen, empty_seen);
        $display("%0d refused pushes; start capacities from the clamped low end to the clamped high end were used",
                 full_seen);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
